// ===== src/msl_pkg.sv =====
// ----------------------------------------------------------------------------
// msl_pkg: shared definitions for the multi-servo slew limiter
// Register indexes, reset values, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package msl_pkg;

	localparam int DEFAULT_SERVO_COUNT = 4;

	localparam int ANGLE_W  = 20;
	localparam int LIMIT_W  = 19;
	localparam int RATE_W   = 16;
	localparam int TIME_W   = 32;
	localparam int ID_W     = 2;
	localparam int ROT_W    = TIME_W + RATE_W;
	localparam int DIFF_W   = ANGLE_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT_ENABLE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT_TRIGGER_MS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT_DURATION_MS = 3'd5;

	// Register reset values.
	localparam logic [LIMIT_W-1:0] RST_MAX_ANGLE         = 19'd102944;
	localparam logic [RATE_W-1:0]  RST_MAX_RATE          = 16'd381;
	localparam logic [TIME_W-1:0]  RST_FAULT_TRIGGER_MS  = 32'd10000;
	localparam logic [TIME_W-1:0]  RST_FAULT_DURATION_MS = 32'd60000;

	// Command codes carried on the input user sideband.
	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SET,
		ST_MUL,
		ST_STEP
	} msl_state_t;

endpackage

// ===== src/msl_sat_add.sv =====
// ----------------------------------------------------------------------------
// msl_sat_add: saturate and accumulate unit
// Limits a signed value to plus or minus an unsigned bound and adds a base.
// ----------------------------------------------------------------------------
module msl_sat_add
	import msl_pkg::*;
(
	input  logic signed [DIFF_W-1:0]  value,
	input  logic        [DIFF_W-1:0]  bound,
	input  logic signed [ANGLE_W-1:0] base,
	output logic signed [ANGLE_W-1:0] result
);

	logic signed [DIFF_W:0] value_x;
	logic signed [DIFF_W:0] bound_x;
	logic signed [DIFF_W:0] limited;
	logic signed [DIFF_W:0] sum;

	always_comb begin
		value_x = {value[DIFF_W-1], value};
		bound_x = {1'b0, bound};
		if (value_x > bound_x) begin
			limited = bound_x;
		end else if (value_x < -bound_x) begin
			limited = -bound_x;
		end else begin
			limited = value_x;
		end
		sum    = {{2{base[ANGLE_W-1]}}, base} + limited;
		result = sum[ANGLE_W-1:0];
	end

endmodule

// ===== src/multi_servo_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// multi_servo_slew_limiter: servo position model with slew limiting
// Clamps set commands, slews positions on ticks and injects one freeze fault.
// ----------------------------------------------------------------------------
// Commands arrive as beats on the slave stream; s_tuser selects a set (0) or
// a tick (1). Results leave on the master stream, one beat per reported
// servo, with m_tlast on the final beat caused by a command.
// A set is accepted in idle; then, in the set state, the clamp runs through
// the shared saturate unit, the fault timer is updated and, with rate
// limiting off, the new position is loaded into the output register.
// A tick with rate limiting on goes through accept, the 32x16 elapsed-time
// multiply, then one servo per cycle through the same saturate unit while
// the output register is free. A tick with rate limiting off leaves the
// sequencer in idle and reports nothing.
// The block works on one command at a time; s_tready is high only in idle.
// A single output register decouples the two sides: when the receiver stalls,
// the sequencer waits on the output register, and the next command may be
// accepted while the final beat is still waiting.
// Reset (arst_n low) restores the register defaults, zeroes all positions,
// targets and times, and clears the fault state. Configuration writes are
// taken in any cycle but should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module multi_servo_slew_limiter
	import msl_pkg::*;
#(
	parameter int SERVO_COUNT = DEFAULT_SERVO_COUNT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Command stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata from bit 0: servo_id[1:0], target_angle[21:2], now_ms[53:22],
	// fault_pick[55:54].
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: command (0 set, 1 tick).
	input  logic                  s_tuser,
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata from bit 0: servo_index[1:0], position[21:2], zero pad[23:22].
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	localparam int IW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SERVO_COUNT - 1);

	// Configuration registers.
	logic [LIMIT_W-1:0] max_angle_q;
	logic               rate_en_q;
	logic [RATE_W-1:0]  max_rate_q;
	logic               fault_en_q;
	logic [TIME_W-1:0]  fault_trigger_q;
	logic [TIME_W-1:0]  fault_duration_q;

	// Servo and fault state.
	logic signed [ANGLE_W-1:0] pos_q [SERVO_COUNT];
	logic signed [ANGLE_W-1:0] tgt_q [SERVO_COUNT];
	logic [TIME_W-1:0] last_update_q;
	logic [TIME_W-1:0] fault_start_q;
	logic              fault_running_q;
	logic              fault_done_q;
	logic              fault_active_q;
	logic [ID_W-1:0]   faulty_q;

	// Captured command.
	logic [ID_W-1:0]           id_q;
	logic signed [ANGLE_W-1:0] req_q;
	logic [TIME_W-1:0]         now_q;
	logic [ID_W-1:0]           pick_q;

	// Sequencer.
	msl_state_t        state_q, state_d;
	logic [IW-1:0]     idx_q;
	logic [ROT_W-1:0]  rot_q;

	// Output register.
	logic                      out_valid_q;
	logic [ID_W-1:0]           out_index_q;
	logic signed [ANGLE_W-1:0] out_pos_q;
	logic                      out_last_q;

	// Datapath and control.
	logic                      accept;
	logic                      out_free;
	logic                      id_ok;
	logic [IW-1:0]             addr;
	logic signed [DIFF_W-1:0]  sat_value;
	logic [DIFF_W-1:0]         sat_bound;
	logic signed [ANGLE_W-1:0] sat_base;
	logic signed [ANGLE_W-1:0] sat_result;
	logic [DIFF_W-1:0]         rot_bound;
	logic                      frozen;
	logic [TIME_W-1:0]         since_start;
	logic [TIME_W-1:0]         elapsed;
	logic                      past_limit;
	logic                      set_go;
	logic                      set_emit;
	logic                      step_go;
	logic                      step_end;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign id_ok    = 32'(id_q) < SERVO_COUNT;

	// The elapsed rotation only matters up to the largest possible difference.
	assign rot_bound = (|rot_q[ROT_W-1:DIFF_W]) ? '1 : rot_q[DIFF_W-1:0];
	assign frozen    = fault_active_q && (32'(faulty_q) == 32'(idx_q));

	// Elapsed time since the last update wraps at the time stamp width.
	assign elapsed = now_q - last_update_q;

	// One time compare serves both the fault start and the fault end checks.
	assign since_start = now_q - fault_start_q;
	assign past_limit  = since_start > (fault_done_q ? fault_duration_q : fault_trigger_q);

	msl_sat_add u_sat (
		.value  (sat_value),
		.bound  (sat_bound),
		.base   (sat_base),
		.result (sat_result)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == CMD_SET) begin
						state_d = ST_SET;
					end else if (rate_en_q) begin
						state_d = ST_MUL;
					end
				end
			end
			ST_SET: begin
				if (set_go) begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (step_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs and shared unit operand selection.
	always_comb begin
		s_tready  = 1'b0;
		set_go    = 1'b0;
		set_emit  = 1'b0;
		step_go   = 1'b0;
		step_end  = 1'b0;
		addr      = IW'(id_q);
		sat_value = {req_q[ANGLE_W-1], req_q};
		sat_bound = {2'b00, max_angle_q};
		sat_base  = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_SET: begin
				set_emit = !rate_en_q && id_ok;
				set_go   = out_free || !set_emit;
			end
			ST_MUL: begin
			end
			ST_STEP: begin
				addr      = idx_q;
				sat_value = {tgt_q[idx_q][ANGLE_W-1], tgt_q[idx_q]}
					- {pos_q[idx_q][ANGLE_W-1], pos_q[idx_q]};
				sat_bound = rot_bound;
				sat_base  = pos_q[idx_q];
				step_go   = out_free;
				step_end  = out_free && (idx_q == LAST_IDX);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_angle_q      <= RST_MAX_ANGLE;
			rate_en_q        <= 1'b0;
			max_rate_q       <= RST_MAX_RATE;
			fault_en_q       <= 1'b0;
			fault_trigger_q  <= RST_FAULT_TRIGGER_MS;
			fault_duration_q <= RST_FAULT_DURATION_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_ANGLE:         max_angle_q      <= cfg_data[LIMIT_W-1:0];
				REG_RATE_LIMIT_ENABLE: rate_en_q        <= cfg_data[0];
				REG_MAX_RATE:          max_rate_q       <= cfg_data[RATE_W-1:0];
				REG_FAULT_ENABLE:      fault_en_q       <= cfg_data[0];
				REG_FAULT_TRIGGER_MS:  fault_trigger_q  <= cfg_data[TIME_W-1:0];
				REG_FAULT_DURATION_MS: fault_duration_q <= cfg_data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Command capture; the payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= s_tdata[1:0];
			req_q  <= s_tdata[21:2];
			now_q  <= s_tdata[53:22];
			pick_q <= s_tdata[55:54];
		end
	end

	// Elapsed rotation for a tick, registered before the slew steps.
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			rot_q <= ROT_W'(elapsed) * ROT_W'(max_rate_q);
		end
	end

	// Servo index counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (state_q == ST_MUL) begin
			idx_q <= '0;
		end else if (step_go && !step_end) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Positions and targets, one entry written per cycle at the shared address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SERVO_COUNT; i++) begin
				pos_q[i] <= '0;
				tgt_q[i] <= '0;
			end
		end else begin
			if (set_go && id_ok) begin
				if (rate_en_q) begin
					tgt_q[addr] <= sat_result;
				end else begin
					pos_q[addr] <= sat_result;
				end
			end
			if (step_go && !frozen) begin
				pos_q[addr] <= sat_result;
			end
		end
	end

	// Time of the last update and the fault timer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_update_q   <= '0;
			fault_start_q   <= '0;
			fault_running_q <= 1'b0;
			fault_done_q    <= 1'b0;
			fault_active_q  <= 1'b0;
			faulty_q        <= '0;
		end else begin
			if ((set_go && rate_en_q) || step_end) begin
				last_update_q <= now_q;
			end
			if (set_go && fault_en_q) begin
				if (!fault_done_q) begin
					if (!fault_running_q) begin
						fault_start_q   <= now_q;
						fault_running_q <= 1'b1;
					end else if (past_limit) begin
						faulty_q       <= pick_q;
						fault_active_q <= 1'b1;
						fault_done_q   <= 1'b1;
					end
				end else if (fault_active_q && past_limit) begin
					fault_active_q <= 1'b0;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (set_go && set_emit) begin
			out_valid_q <= 1'b1;
		end else if (step_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (set_go && set_emit) begin
			out_index_q <= id_q;
			out_pos_q   <= sat_result;
			out_last_q  <= 1'b1;
		end else if (step_go) begin
			out_index_q <= ID_W'(idx_q);
			out_pos_q   <= frozen ? pos_q[idx_q] : sat_result;
			out_last_q  <= step_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_pos_q, out_index_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== src/msl_checker.sv =====
// ----------------------------------------------------------------------------
// msl_checker: port-level assertions for the multi-servo slew limiter
// Watches the streams of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module msl_checker
	import msl_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	// A stalled result beat holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// A new command is taken only once a report frame is down to its last beat.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !(m_tvalid && !m_tlast))
		else $error("command accepted in the middle of a report frame");

	// Within a report frame the next beat follows without a gap.
	a_frame_dense: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a report frame");

endmodule

bind multi_servo_slew_limiter msl_checker u_msl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_servo_slew_limiter
// Sends set and tick commands on the input stream with random bursts and gaps,
// accepts position reports under random back-pressure, predicts every report
// from a behavioral copy of the servo, slew and fault logic, and compares them
// in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import msl_pkg::*;

	localparam int NUM_SERVOS = DEFAULT_SERVO_COUNT;
	// Settling margin for a tick with slewing on, the output register and any
	// command that leaves no report behind.
	localparam int SETTLE_CYCLES = NUM_SERVOS + 6;
	// Long receiver hold-off used to back the block up into its input.
	localparam int LONG_HOLDOFF = 300;
	// Cycles without any accepted beat before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int MAX_REPORTED = 10;

	// One command as the sender sees it.
	typedef struct packed {
		logic                      cmd;
		logic [ID_W-1:0]           id;
		logic signed [ANGLE_W-1:0] angle;
		logic [TIME_W-1:0]         now;
		logic [1:0]                pick;
	} servo_cmd_t;

	// One position report.
	typedef struct packed {
		logic [ID_W-1:0]           index;
		logic signed [ANGLE_W-1:0] position;
		logic                      last;
	} servo_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// s_tdata from bit 0: servo_id, target_angle, now_ms, fault_pick.
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// s_tuser: command (set or tick).
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// m_tdata from bit 0: servo_index, position, zero pad.
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	multi_servo_slew_limiter #(
		.SERVO_COUNT(NUM_SERVOS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Behavioral copy of the block: register shadows and servo/fault state.
	// ------------------------------------------------------------------------
	logic [LIMIT_W-1:0]        angle_limit = RST_MAX_ANGLE;
	logic                      slew_on = 1'b0;
	logic [RATE_W-1:0]         slew_rate = RST_MAX_RATE;
	logic                      fault_allowed = 1'b0;
	logic [TIME_W-1:0]         fault_delay_ms = RST_FAULT_TRIGGER_MS;
	logic [TIME_W-1:0]         fault_end_ms = RST_FAULT_DURATION_MS;

	logic signed [ANGLE_W-1:0] servo_pos [NUM_SERVOS];
	logic signed [ANGLE_W-1:0] servo_goal [NUM_SERVOS];
	logic [TIME_W-1:0]         last_move_ms = '0;
	logic [TIME_W-1:0]         fault_origin_ms = '0;
	logic                      fault_armed = 1'b0;
	logic                      fault_spent = 1'b0;
	logic                      fault_frozen = 1'b0;
	logic [1:0]                frozen_servo = '0;

	initial begin
		for (int i = 0; i < NUM_SERVOS; i++) begin
			servo_pos[i] = '0;
			servo_goal[i] = '0;
		end
	end

	servo_cmd_t    pending_commands [$];
	servo_report_t expected_positions [$];
	int            cmds_queued = 0;
	int            cmds_accepted = 0;
	int            mismatches = 0;

	// Works out the reports caused by one accepted command and updates the
	// behavioral state the same way the block must.
	function automatic void predict_positions(input servo_cmd_t c);
		longint        lim;
		longint        val;
		longint        max_rot;
		longint        diff;
		longint        moved;
		logic [TIME_W-1:0] since;
		servo_report_t r;
		if (c.cmd == CMD_SET) begin
			// Clamp the request symmetrically to the configured magnitude.
			lim = longint'(angle_limit);
			val = longint'(signed'(c.angle));
			if (val > lim)
				val = lim;
			if (val < -lim)
				val = -lim;
			if (!slew_on) begin
				servo_pos[c.id] = val[ANGLE_W-1:0];
				r.index = c.id;
				r.position = val[ANGLE_W-1:0];
				r.last = 1'b1;
				expected_positions.push_back(r);
			end else begin
				last_move_ms = c.now;
				servo_goal[c.id] = val[ANGLE_W-1:0];
			end
			// The fault timer is driven by set commands only. The first one
			// starts it, a later one past the trigger delay freezes the picked
			// servo, and once spent the fault can only be cleared.
			since = c.now - fault_origin_ms;
			if (fault_allowed && !fault_spent) begin
				if (!fault_armed) begin
					fault_origin_ms = c.now;
					fault_armed = 1'b1;
				end else if (since > fault_delay_ms) begin
					frozen_servo = c.pick;
					fault_frozen = 1'b1;
					fault_spent = 1'b1;
				end
			end else if (fault_allowed && fault_frozen) begin
				if (since > fault_end_ms)
					fault_frozen = 1'b0;
			end
		end else if (slew_on) begin
			// Elapsed time wraps modulo 2^32; the step bound is exact in 48 bits.
			since = c.now - last_move_ms;
			max_rot = longint'(since) * longint'(slew_rate);
			for (int i = 0; i < NUM_SERVOS; i++) begin
				if (!(fault_frozen && frozen_servo == i)) begin
					diff = longint'(servo_goal[i]) - longint'(servo_pos[i]);
					if (diff > max_rot)
						diff = max_rot;
					if (diff < -max_rot)
						diff = -max_rot;
					moved = longint'(servo_pos[i]) + diff;
					servo_pos[i] = moved[ANGLE_W-1:0];
				end
				r.index = i[ID_W-1:0];
				r.position = servo_pos[i];
				r.last = (i == NUM_SERVOS - 1);
				expected_positions.push_back(r);
			end
			last_move_ms = c.now;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offers queued commands in bursts of random length separated by
	// random gaps. A beat that is not taken is held unchanged.
	// ------------------------------------------------------------------------
	servo_cmd_t cmd_on_bus;
	int         burst_left = 1;
	int         gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : drive_commands
		servo_cmd_t nxt;
		logic       offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_positions(cmd_on_bus);
				cmds_accepted <= cmds_accepted + 1;
			end
			offer = s_tvalid && !s_tready;
			if (!offer) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_commands.size() != 0) begin
					nxt = pending_commands.pop_front();
					s_tdata <= {nxt.pick, nxt.now, nxt.angle, nxt.id};
					s_tuser <= nxt.cmd;
					cmd_on_bus <= nxt;
					offer = 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						// Back-to-back bursts happen too, so some commands see no gap.
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
			s_tvalid <= offer;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: the stall rate is switched at random between none, light,
	// heavy and near-total. On request it also holds off for a long stretch
	// so the output register fills and the block stops taking commands.
	// ------------------------------------------------------------------------
	int holdoff_asks = 0;
	int holdoff_served = 0;
	int holdoff_left = 0;
	int stall_pct = 0;
	int rx_cycle = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (holdoff_left != 0) begin
				holdoff_left <= holdoff_left - 1;
				m_tready <= 1'b0;
			end else if (holdoff_served != holdoff_asks) begin
				holdoff_served <= holdoff_served + 1;
				holdoff_left <= LONG_HOLDOFF;
				m_tready <= 1'b0;
			end else begin
				if (rx_cycle % 64 == 0) begin
					case ($urandom_range(0, 4))
						0, 1: stall_pct <= 0;
						2: stall_pct <= 30;
						3: stall_pct <= 60;
						default: stall_pct <= 90;
					endcase
				end
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every accepted result beat is checked against the oldest
	// outstanding prediction.
	// ------------------------------------------------------------------------
	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : check_reports
		servo_report_t want;
		logic [ID_W-1:0]    got_index;
		logic [ANGLE_W-1:0] got_position;
		if (arst_n && m_tvalid && m_tready) begin
			got_index = m_tdata[ID_W-1:0];
			got_position = m_tdata[ID_W +: ANGLE_W];
			if (expected_positions.size() == 0) begin
				log_mismatch($sformatf("unexpected beat index %0d position %0d last %0b",
					got_index, $signed(got_position), m_tlast));
			end else begin
				want = expected_positions.pop_front();
				if (got_index != want.index || got_position != want.position ||
						m_tlast != want.last)
					log_mismatch($sformatf(
						"expected index %0d position %0d last %0b, got %0d %0d %0b",
						want.index, want.position, want.last,
						got_index, $signed(got_position), m_tlast));
			end
		end
	end

	// Watchdog: a long run of cycles with no beat on either side means a hang.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic queue_set(input logic [1:0] id, input int angle,
			input logic [TIME_W-1:0] now, input logic [1:0] pick);
		servo_cmd_t c;
		c.cmd = CMD_SET;
		c.id = id;
		c.angle = angle[ANGLE_W-1:0];
		c.now = now;
		c.pick = pick;
		pending_commands.push_back(c);
		cmds_queued++;
	endtask

	// Ticks ignore servo id, angle and pick; those fields carry random bits.
	task automatic queue_tick(input logic [TIME_W-1:0] now);
		servo_cmd_t c;
		c.cmd = CMD_TICK;
		c.id = ID_W'($urandom_range(0, 3));
		c.angle = ANGLE_W'($urandom);
		c.now = now;
		c.pick = 2'($urandom_range(0, 3));
		pending_commands.push_back(c);
		cmds_queued++;
	endtask

	// Waits until every queued command has been taken and every predicted
	// report has arrived, then lets the block finish any command that leaves
	// no report behind.
	task automatic wait_idle();
		while (cmds_accepted != cmds_queued || expected_positions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_MAX_ANGLE:         angle_limit = value[LIMIT_W-1:0];
			REG_RATE_LIMIT_ENABLE: slew_on = value[0];
			REG_MAX_RATE:          slew_rate = value[RATE_W-1:0];
			REG_FAULT_ENABLE:      fault_allowed = value[0];
			REG_FAULT_TRIGGER_MS:  fault_delay_ms = value;
			REG_FAULT_DURATION_MS: fault_end_ms = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin
		logic [TIME_W-1:0] clock_ms;
		int                angle;
		int                lim;
		int                roll;
		logic              ticks_pay;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Direct mode at reset defaults: the clamp at both ends, exactly at the
		// limit and one past it, and a tick that must report nothing.
		queue_set(2'd0, 524287, 32'd0, 2'd0);
		queue_set(2'd1, -524288, 32'd0, 2'd1);
		queue_set(2'd2, 102944, 32'd0, 2'd2);
		queue_set(2'd3, -102945, 32'd0, 2'd3);
		queue_tick(32'd0);
		wait_idle();

		// Widest clamp: the most negative request lands one above the field minimum.
		write_reg(REG_MAX_ANGLE, 32'd524287);
		queue_set(2'd0, -524288, 32'd0, 2'd0);
		queue_set(2'd1, 524287, 32'd0, 2'd0);
		wait_idle();
		write_reg(REG_MAX_ANGLE, 32'd0);
		queue_set(2'd2, 123, 32'd0, 2'd0);
		wait_idle();

		// Slewing with the fault armed. Time starts just below the wrap point,
		// so the first tick measures its elapsed time across the wrap, and the
		// set at 1000 is past the trigger delay and freezes servo 2.
		write_reg(REG_MAX_ANGLE, 32'd524287);
		write_reg(REG_RATE_LIMIT_ENABLE, 32'd1);
		write_reg(REG_MAX_RATE, 32'd381);
		write_reg(REG_FAULT_TRIGGER_MS, 32'd1000);
		write_reg(REG_FAULT_DURATION_MS, 32'd5000);
		write_reg(REG_FAULT_ENABLE, 32'd1);
		queue_set(2'd0, 524287, 32'hFFFF_FF00, 2'd1);
		queue_set(2'd1, -524288, 32'hFFFF_FF80, 2'd0);
		queue_tick(32'h0000_0010);
		queue_set(2'd2, 1000, 32'd1000, 2'd2);
		queue_tick(32'd1100);
		wait_idle();

		// With the fault enable cleared the frozen servo must stay frozen even
		// well past the fault's end time; a tick with no elapsed time moves nothing.
		write_reg(REG_FAULT_ENABLE, 32'd0);
		queue_set(2'd3, -2000, 32'd9000, 2'd0);
		queue_tick(32'd9000);
		wait_idle();
		write_reg(REG_FAULT_ENABLE, 32'd1);
		queue_set(2'd2, 5, 32'd9000, 2'd3);
		queue_tick(32'd9100);
		wait_idle();

		// Zero rate holds everything; full rate with the largest elapsed time
		// finishes every move in one tick.
		write_reg(REG_MAX_RATE, 32'd0);
		queue_tick(32'd20000);
		wait_idle();
		write_reg(REG_MAX_RATE, 32'd65535);
		queue_tick(32'd20001);
		queue_set(2'd0, -524288, 32'd20001, 2'd0);
		queue_tick(32'd20000);
		wait_idle();
		write_reg(REG_RATE_LIMIT_ENABLE, 32'd0);
		queue_tick(32'd30000);
		queue_set(2'd3, 77, 32'd30000, 2'd3);
		wait_idle();

		// Random phases. Each one rewrites every register, then sends a random mix
		// of sets and ticks on an advancing clock, with occasional jumps
		// to an arbitrary time stamp as noise.
		clock_ms = $urandom;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 5))
				0: write_reg(REG_MAX_ANGLE, 32'd0);
				1: write_reg(REG_MAX_ANGLE, 32'd524287);
				2: write_reg(REG_MAX_ANGLE, 32'd102944);
				default: write_reg(REG_MAX_ANGLE, $urandom_range(0, 524287));
			endcase
			// Every fourth phase runs in direct mode.
			ticks_pay = (phase % 4 != 3);
			write_reg(REG_RATE_LIMIT_ENABLE, {31'd0, ticks_pay});
			case ($urandom_range(0, 5))
				0: write_reg(REG_MAX_RATE, 32'd0);
				1: write_reg(REG_MAX_RATE, 32'd65535);
				2, 3: write_reg(REG_MAX_RATE, $urandom_range(1, 64));
				default: write_reg(REG_MAX_RATE, $urandom_range(0, 65535));
			endcase
			write_reg(REG_FAULT_ENABLE, $urandom_range(0, 1));
			case ($urandom_range(0, 2))
				0: write_reg(REG_FAULT_TRIGGER_MS, 32'd0);
				1: write_reg(REG_FAULT_TRIGGER_MS, 32'hFFFF_FFFF);
				default: write_reg(REG_FAULT_TRIGGER_MS, $urandom);
			endcase
			case ($urandom_range(0, 2))
				0: write_reg(REG_FAULT_DURATION_MS, 32'd0);
				1: write_reg(REG_FAULT_DURATION_MS, 32'hFFFF_FFFF);
				default: write_reg(REG_FAULT_DURATION_MS, $urandom);
			endcase

			lim = int'(angle_limit);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll = $urandom_range(0, 99);
				if (roll >= 92) begin
					clock_ms = $urandom;
				end else begin
					clock_ms = clock_ms + $urandom_range(0, 40);
				end
				// In direct mode ticks are rare since they cause nothing.
				if (roll < (ticks_pay ? 35 : 90) || roll >= 96) begin
					case ($urandom_range(0, 9))
						0: angle = 524287;
						1: angle = -524288;
						2: angle = lim;
						3: angle = -lim;
						4: angle = lim + 1;
						5: angle = -lim - 1;
						default: angle = $urandom_range(0, 1048575) - 524288;
					endcase
					queue_set(2'($urandom_range(0, 3)), angle, clock_ms,
						2'($urandom_range(0, 3)));
				end else begin
					queue_tick(clock_ms);
				end
			end

			// Two phases stall the receiver for a long stretch while the driver
			// still has commands to offer, so the block backs up into its input.
			if (phase == 1 || phase == 4) begin
				@(posedge clk);
				holdoff_asks <= holdoff_asks + 1;
			end
			wait_idle();
		end

		if (mismatches == 0 && expected_positions.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
